// ===== rtl/bmp_pkg.sv =====
// Shared constants, codes and inter-module structs of the bitmap pixel decoder.
// Depends on nothing; every other file but bmp_checker refers to it by scoped names.
`timescale 1ns / 1ps

package bmp_pkg;

    // Size limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int PAL_DEPTH  = 256;

    localparam int PAL_AW  = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
    localparam int WCNT_W  = $clog2(MAX_WIDTH + 1);   // column count, holds MAX_WIDTH
    localparam int HCNT_W  = $clog2(MAX_HEIGHT + 1);  // clamped height
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int BITS_W  = WCNT_W + 5;              // row bits, up to 24 * width
    localparam int RBC_W   = BITS_W - 2;              // row byte count and stride
    localparam int CFG_W   = 13;                      // widest register

    // Register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_BITS_PER_PIXEL = 2'd2;

    // Word kinds on the input stream
    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_DATA    = 1'b1;

    // Status codes
    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_UNSUPPORTED = 1'b1;

    typedef enum logic [2:0] {
        DEPTH_1,
        DEPTH_4,
        DEPTH_8,
        DEPTH_24,
        DEPTH_BAD
    } depth_t;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
        logic [23:0]       rgb;
    } pal_wr_t;

    typedef struct packed {
        logic              valid;
        logic              from_pal;   // color comes from the palette read
        logic              pal_black;  // index beyond the palette
        logic [PAL_AW-1:0] pal_addr;
        logic [23:0]       rgb;        // direct color {red, green, blue}
        logic [11:0]       column;
        logic [11:0]       row;
        logic              last;
        logic              done;
        logic              status;
    } pix_req_t;

endpackage

// ===== rtl/bmp_palette.sv =====
// Palette store: one write port, one read port with registered data.
// Depends on bmp_pkg for depth and the write struct.
`timescale 1ns / 1ps

module bmp_palette
(
    input  logic                      clk,
    input  bmp_pkg::pal_wr_t          wr,
    input  logic                      rd_en,
    input  logic [bmp_pkg::PAL_AW-1:0] rd_addr,
    output logic [23:0]               rd_data
);

    logic [23:0] mem [bmp_pkg::PAL_DEPTH];
    logic [23:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.rgb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bmp_unpacker.sv =====
// Config registers, row/column tracking and per-word pixel sequencing.
// Depends on bmp_pkg; feeds the palette and the output stage in the top level.
`timescale 1ns / 1ps

module bmp_unpacker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [bmp_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [39:0]               s_tdata,
    input  logic                      s_tuser,
    input  logic                      adv,
    output bmp_pkg::pix_req_t         req,
    output bmp_pkg::pal_wr_t          pal_wr
);

    localparam int WC = bmp_pkg::WCNT_W;
    localparam int HC = bmp_pkg::HCNT_W;
    localparam int RW = bmp_pkg::ROW_W;
    localparam int BW = bmp_pkg::BITS_W;
    localparam int RB = bmp_pkg::RBC_W;

    // raw config
    logic [12:0] width_reg,  width_next;
    logic [12:0] height_reg, height_next;
    logic [5:0]  bpp_reg,    bpp_next;
    logic        cfg_hit;

    // derived config, always consistent with the raw registers
    logic [WC-1:0]     w_reg,      w_next;
    logic [HC-1:0]     h_reg,      h_next;
    bmp_pkg::depth_t   depth_reg,  depth_next;
    logic [RB-1:0]     stride_reg, stride_next;
    logic [RB-1:0]     pixb_reg,   pixb_next;
    logic [BW-1:0]     bits_n;
    logic [BW:0]       stride_sum;
    logic [BW:0]       pixb_sum;

    // held word
    logic        u_valid_reg;
    logic        u_op_reg;
    logic [7:0]  u_byte_reg;
    logic [7:0]  u_idx_reg;
    logic [23:0] u_rgb_reg;
    logic [2:0]  k_reg, k_next;

    // position
    logic [WC-1:0] col_reg,     col_next;
    logic [RW-1:0] row_reg,     row_next;
    logic [RB-1:0] rbc_reg,     rbc_next;
    logic [1:0]    phase_reg,   phase_next;
    logic [15:0]   partial_reg, partial_next;

    logic          in_px;
    logic [3:0]    ppb;
    logic          emit;
    logic          last_pix;
    logic          step_last;
    logic          bad;
    logic          work;
    logic [WC-1:0] col_inc;
    logic [RB-1:0] rbc_inc;
    logic [RW:0]   row_inc;
    logic [7:0]    pix_idx;
    logic          accept;

    // ---------------- configuration ----------------
    assign cfg_hit = cfg_we && (cfg_index == bmp_pkg::REG_IMAGE_WIDTH
                             || cfg_index == bmp_pkg::REG_IMAGE_HEIGHT
                             || cfg_index == bmp_pkg::REG_BITS_PER_PIXEL);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        bpp_next    = bpp_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bmp_pkg::REG_IMAGE_WIDTH:    width_next  = cfg_data;
                bmp_pkg::REG_IMAGE_HEIGHT:   height_next = cfg_data;
                bmp_pkg::REG_BITS_PER_PIXEL: bpp_next    = cfg_data[5:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        // width/height clamp: 0 acts as 1, beyond the limit as the limit
        if (width_next == 13'd0)
            w_next = WC'(1);
        else if ({1'b0, width_next} > 14'(bmp_pkg::MAX_WIDTH))
            w_next = WC'(bmp_pkg::MAX_WIDTH);
        else
            w_next = WC'(width_next);

        if (height_next == 13'd0)
            h_next = HC'(1);
        else if ({1'b0, height_next} > 14'(bmp_pkg::MAX_HEIGHT))
            h_next = HC'(bmp_pkg::MAX_HEIGHT);
        else
            h_next = HC'(height_next);

        case (bpp_next)
            6'd1:    depth_next = bmp_pkg::DEPTH_1;
            6'd4:    depth_next = bmp_pkg::DEPTH_4;
            6'd8:    depth_next = bmp_pkg::DEPTH_8;
            6'd24:   depth_next = bmp_pkg::DEPTH_24;
            default: depth_next = bmp_pkg::DEPTH_BAD;
        endcase

        case (depth_next)
            bmp_pkg::DEPTH_1:  bits_n = BW'(w_next);
            bmp_pkg::DEPTH_4:  bits_n = BW'(w_next) << 2;
            bmp_pkg::DEPTH_8:  bits_n = BW'(w_next) << 3;
            bmp_pkg::DEPTH_24: bits_n = (BW'(w_next) << 4) + (BW'(w_next) << 3);
            default:           bits_n = '0;
        endcase

        // stride rounds the row up to whole 32-bit words
        stride_sum  = {1'b0, bits_n} + (BW+1)'(31);
        stride_next = RB'(stride_sum >> 3) & ~RB'(3);
        pixb_sum    = {1'b0, bits_n} + (BW+1)'(7);
        pixb_next   = RB'(pixb_sum >> 3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
            bpp_reg    <= 6'd8;
            w_reg      <= WC'(1);
            h_reg      <= HC'(1);
            depth_reg  <= bmp_pkg::DEPTH_8;
            stride_reg <= RB'(4);
            pixb_reg   <= RB'(1);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            bpp_reg    <= bpp_next;
            w_reg      <= w_next;
            h_reg      <= h_next;
            depth_reg  <= depth_next;
            stride_reg <= stride_next;
            pixb_reg   <= pixb_next;
        end
    end

    // ---------------- per-step decode ----------------
    assign bad     = (depth_reg == bmp_pkg::DEPTH_BAD);
    assign in_px   = (rbc_reg < pixb_reg);
    assign col_inc = col_reg + WC'(1);
    assign rbc_inc = rbc_reg + RB'(1);
    assign row_inc = {1'b0, row_reg} + (RW+1)'(1);

    always_comb
    begin
        case (depth_reg)
            bmp_pkg::DEPTH_1:  ppb = 4'd8;
            bmp_pkg::DEPTH_4:  ppb = 4'd2;
            bmp_pkg::DEPTH_8:  ppb = 4'd1;
            bmp_pkg::DEPTH_24: ppb = (phase_reg >= 2'd2) ? 4'd1 : 4'd0;
            default:           ppb = 4'd0;
        endcase

        case (depth_reg)
            bmp_pkg::DEPTH_1:  pix_idx = {7'd0, u_byte_reg[3'd7 - k_reg]};
            bmp_pkg::DEPTH_4:  pix_idx = k_reg[0] ? {4'd0, u_byte_reg[3:0]}
                                                  : {4'd0, u_byte_reg[7:4]};
            default:           pix_idx = u_byte_reg;
        endcase
    end

    assign emit      = in_px && (col_reg < w_reg) && ({1'b0, k_reg} < ppb);
    assign last_pix  = ({1'b0, k_reg} == ppb - 4'd1) || (col_inc >= w_reg);
    assign step_last = (u_op_reg == bmp_pkg::OP_PALETTE) || bad || !emit || last_pix;
    assign work      = adv && u_valid_reg && (u_op_reg == bmp_pkg::OP_DATA) && !bad;

    assign s_tready = !u_valid_reg || (adv && step_last);
    assign accept   = s_tvalid && s_tready;

    // ---------------- requests ----------------
    always_comb
    begin
        req           = '0;
        req.pal_addr  = pix_idx[bmp_pkg::PAL_AW-1:0];
        req.pal_black = ({1'b0, pix_idx} >= 9'(bmp_pkg::PAL_DEPTH));
        if (u_valid_reg && u_op_reg == bmp_pkg::OP_DATA)
        begin
            if (bad)
            begin
                req.valid  = 1'b1;
                req.last   = 1'b1;
                req.status = bmp_pkg::STATUS_UNSUPPORTED;
            end
            else if (emit)
            begin
                req.valid    = 1'b1;
                req.from_pal = (depth_reg != bmp_pkg::DEPTH_24);
                req.rgb      = {u_byte_reg, partial_reg};
                req.column   = 12'(col_reg);
                req.row      = 12'(h_reg - HC'(1) - HC'(row_reg));
                req.last     = last_pix;
                req.done     = (HC'(row_reg) == h_reg - HC'(1)) && (col_inc == w_reg);
                req.status   = bmp_pkg::STATUS_OK;
            end
        end
    end

    assign pal_wr.en   = adv && u_valid_reg && (u_op_reg == bmp_pkg::OP_PALETTE)
                      && ({1'b0, u_idx_reg} < 9'(bmp_pkg::PAL_DEPTH));
    assign pal_wr.addr = u_idx_reg[bmp_pkg::PAL_AW-1:0];
    assign pal_wr.rgb  = u_rgb_reg;

    // ---------------- position update ----------------
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        rbc_next     = rbc_reg;
        phase_next   = phase_reg;
        partial_next = partial_reg;
        k_next       = k_reg;

        if (cfg_hit)
        begin
            col_next     = '0;
            row_next     = '0;
            rbc_next     = '0;
            phase_next   = 2'd0;
            partial_next = 16'd0;
        end
        else if (work)
        begin
            if (emit)
                col_next = col_inc;
            if (!step_last)
                k_next = k_reg + 3'd1;
            else
            begin
                k_next = 3'd0;
                if (in_px && depth_reg == bmp_pkg::DEPTH_24)
                begin
                    case (phase_reg)
                        2'd0:
                        begin
                            partial_next = {8'd0, u_byte_reg};
                            phase_next   = 2'd1;
                        end
                        2'd1:
                        begin
                            partial_next = {u_byte_reg, partial_reg[7:0]};
                            phase_next   = 2'd2;
                        end
                        default:
                        begin
                            partial_next = 16'd0;
                            phase_next   = 2'd0;
                        end
                    endcase
                end
                if (rbc_inc >= stride_reg)
                begin
                    rbc_next     = '0;
                    col_next     = '0;
                    phase_next   = 2'd0;
                    partial_next = 16'd0;
                    row_next     = ((RW+1)'(h_reg) <= row_inc) ? '0 : RW'(row_inc);
                end
                else
                    rbc_next = rbc_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            rbc_reg     <= '0;
            phase_reg   <= 2'd0;
            partial_reg <= 16'd0;
            k_reg       <= 3'd0;
            u_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            rbc_reg     <= rbc_next;
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            k_reg       <= k_next;
            if (s_tready)
                u_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            u_op_reg   <= s_tuser;
            u_idx_reg  <= s_tdata[7:0];
            u_rgb_reg  <= {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
            u_byte_reg <= s_tdata[39:32];
        end
    end

endmodule

// ===== rtl/bmp_pixel_decoder.sv =====
// Top level of the uncompressed bitmap pixel decoder: unpacker, palette, output register.
// Depends on bmp_pkg, bmp_unpacker and bmp_palette.
`timescale 1ns / 1ps

// Decodes uncompressed bitmap pixel data into RGB pixels. Load the palette first with
// palette words (tuser = 0), each written in one cycle; then stream image bytes in file
// order (tuser = 1). Every byte is held in an input register and sequenced out one
// pixel per cycle on the single result port: a byte gives 8 pixels at 1 bit per pixel
// (fewer at the end of a row), 2 at 4 bits, 1 at 8 bits and 1 per 24-bit triple;
// padding bytes and the first two bytes of a 24-bit triple give no word. That one-pixel-
// per-cycle output port sets the rate. A byte's pixel words pass through the input
// register and then the output register; the palette read is registered at the same
// edge as the output register. A new word is taken in the same cycle the previous one
// finishes. While a result waits on m_tready the pipe holds, so s_tready drops unless
// the input register is empty. Rows come bottom-up; pixel_row is height-1-file row.
// Any depth other than 1, 4, 8 or 24 gives one word with status set per byte and no
// position change. The palette is not cleared by reset: read only entries written.
// Config writes (index 0 width, 1 height, 2 bits per pixel) restart the image and must
// be made only while the block is idle.
module bmp_pixel_decoder
(
    input  logic                      clk,
    input  logic                      rst_n,
    // config write port
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [bmp_pkg::CFG_W-1:0] cfg_data,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [39:0]               s_tdata,  // palette_index, palette_red, palette_green,
                                                // palette_blue, data_byte
    input  logic                      s_tuser,  // opcode
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [47:0]               m_tdata,  // pixel_column, pixel_row, red, green, blue
    output logic                      m_tlast,  // last_of_run
    output logic [1:0]                m_tuser   // image_done, status
);

    bmp_pkg::pix_req_t req;
    bmp_pkg::pal_wr_t  pal_wr;
    logic              adv;
    logic [23:0]       pal_rgb;
    logic [23:0]       rgb;

    // output register
    logic        m_valid_reg;
    logic        from_pal_reg;
    logic        black_reg;
    logic [23:0] rgb_reg;
    logic [11:0] col_reg;
    logic [11:0] row_reg;
    logic        last_reg;
    logic        done_reg;
    logic        status_reg;

    // whole pipe moves when the output register is free or being emptied
    assign adv = !m_valid_reg || m_tready;

    bmp_unpacker u_unpacker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .adv       (adv),
        .req       (req),
        .pal_wr    (pal_wr)
    );

    // read data lands alongside the rest of the output register
    bmp_palette u_palette
    (
        .clk     (clk),
        .wr      (pal_wr),
        .rd_en   (adv && req.valid && req.from_pal),
        .rd_addr (req.pal_addr),
        .rd_data (pal_rgb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && req.valid)
        begin
            from_pal_reg <= req.from_pal;
            black_reg    <= req.pal_black;
            rgb_reg      <= req.rgb;
            col_reg      <= req.column;
            row_reg      <= req.row;
            last_reg     <= req.last;
            done_reg     <= req.done;
            status_reg   <= req.status;
        end
    end

    always_comb
    begin
        if (!from_pal_reg)
            rgb = rgb_reg;
        else if (black_reg)
            rgb = 24'd0;
        else
            rgb = pal_rgb;
    end

    assign m_tvalid = m_valid_reg;
    // rgb is {red, green, blue}
    assign m_tdata  = {rgb[7:0], rgb[15:8], rgb[23:16], row_reg, col_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = {status_reg, done_reg};

endmodule

// ===== rtl/bmp_checker.sv =====
// Port-level checks on the result stream of the bitmap pixel decoder, attached by bind.
// Depends on the top level bmp_pixel_decoder.
`timescale 1ns / 1ps

module bmp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser
);

    // unsupported depth word is a lone, all-zero word
    a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && m_tdata == 48'd0 && !m_tuser[0])
        else $error("unsupported-depth word malformed");

    // final pixel of the image ends its byte's run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("image_done without last_of_run");

    // final pixel sits on the top output row
    a_done_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[23:12] == 12'd0)
        else $error("image_done off output row zero");

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output word changed while stalled");

endmodule

bind bmp_pixel_decoder bmp_checker u_bmp_checker (.*);
